FILE: rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared definitions for the page frame replacement block
// Register map, reset values and the selection flags passed between modules.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int FRAME_W    = 3;
    localparam int CFG_W      = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [0:0]       REG_FRAMES_IN_USE   = 1'b0;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 4'd3;

    typedef struct packed {
        logic hit;
        logic fill_empty;
    } t_pick;

endpackage

FILE: rtl/page_frame_replacement.sv
// ----------------------------------------------------------------------------
// page_frame_replacement: LRU page replacement over a small set of frames
// Looks up each page reference, refills or evicts on a miss and counts faults.
// ----------------------------------------------------------------------------
// Usage: one page reference enters per slave-side transaction, with the page
// in s_axis_tdata and the new-run flag in s_axis_tuser. Each reference gives
// exactly one master-side transaction carrying hit in m_axis_tuser and the
// frame, fault count and access count in m_axis_tdata.
// The block takes one transaction per cycle while s_axis_tready is high. A
// reference is captured in an input register, handled by one pass of lookup
// and rank update once the output register can take it, and its result sits
// in the output register. Frame state is updated in that single pass, so
// back-to-back references always see the state left by the previous one.
// When the receiver stalls, the output register holds its result and the
// input register fills; s_axis_tready drops only once both are occupied.
// Reset empties all frames, clears ranks and counters and sets
// frames_in_use to 3. The APB register frames_in_use (address 0) should be
// written only while no reference is in flight.
// ----------------------------------------------------------------------------
module page_frame_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: page.
    input  logic [((PAGE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // Fields from bit 0: new_run.
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: frame, fault_count, access_count.
    output logic [((pfr_pkg::FRAME_W+2*COUNT_BITS+7)/8)*8-1:0] m_axis_tdata,
    // Fields from bit 0: hit.
    output logic                              m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pfr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pfr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int IDX_BITS   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int OUT_DATA_W = ((pfr_pkg::FRAME_W + 2 * COUNT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - pfr_pkg::FRAME_W - 2 * COUNT_BITS;

    logic [pfr_pkg::CFG_W-1:0] r_frames_in_use;

    logic                  r_in_vld;
    logic [PAGE_BITS-1:0]  r_in_page;
    logic                  r_in_new_run;

    logic [MAX_FRAMES-1:0] r_valid;
    logic [PAGE_BITS-1:0]  r_page [MAX_FRAMES];
    logic [IDX_BITS-1:0]   r_rank [MAX_FRAMES];
    logic [COUNT_BITS-1:0] r_faults;
    logic [COUNT_BITS-1:0] r_accesses;

    logic                        r_out_vld;
    logic                        r_out_hit;
    logic [pfr_pkg::FRAME_W-1:0] r_out_frame;
    logic [COUNT_BITS-1:0]       r_out_faults;
    logic [COUNT_BITS-1:0]       r_out_accesses;

    logic [MAX_FRAMES-1:0] n_valid;
    logic [IDX_BITS-1:0]   n_rank [MAX_FRAMES];
    logic [COUNT_BITS-1:0] n_faults;
    logic [COUNT_BITS-1:0] n_accesses;

    logic                  w_adv;
    logic                  w_fire;
    logic [MAX_FRAMES-1:0] w_valid;
    logic [IDX_BITS-1:0]   w_rank [MAX_FRAMES];
    logic [COUNT_BITS-1:0] w_faults;
    logic [COUNT_BITS-1:0] w_accesses;
    logic [MAX_FRAMES-1:0] w_match;
    logic [MAX_FRAMES-1:0] w_in_win;
    logic [IDX_BITS-1:0]   w_idx;
    pfr_pkg::t_pick        w_pick;
    logic [IDX_BITS-1:0]   w_old_rank;
    logic [IDX_BITS+pfr_pkg::FRAME_W-1:0] w_idx_ext;
    logic                  w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == pfr_pkg::REG_FRAMES_IN_USE);

    always_comb begin
        if (paddr[2] == pfr_pkg::REG_FRAMES_IN_USE) begin
            prdata = {{(pfr_pkg::APB_DATA_W-pfr_pkg::CFG_W){1'b0}}, r_frames_in_use};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= pfr_pkg::FRAMES_IN_USE_RESET;
        end else if (w_cfg_wr) begin
            r_frames_in_use <= pwdata[pfr_pkg::CFG_W-1:0];
        end
    end

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign w_fire        = r_in_vld && w_adv;
    assign s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_page    <= s_axis_tdata[PAGE_BITS-1:0];
            r_in_new_run <= s_axis_tuser;
        end
    end

    always_comb begin
        w_valid    = r_in_new_run ? '0 : r_valid;
        w_faults   = r_in_new_run ? '0 : r_faults;
        w_accesses = r_in_new_run ? '0 : r_accesses;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            w_rank[k]   = r_in_new_run ? '0 : r_rank[k];
            w_match[k]  = w_valid[k] && (r_page[k] == r_in_page);
            w_in_win[k] = (k == 0) || (k < int'(r_frames_in_use));
        end
    end

    pfr_select #(
        .MAX_FRAMES (MAX_FRAMES),
        .IDX_BITS   (IDX_BITS)
    ) u_select (
        .i_match  (w_match),
        .i_valid  (w_valid),
        .i_in_win (w_in_win),
        .i_rank   (w_rank),
        .o_idx    (w_idx),
        .o_pick   (w_pick)
    );

    assign w_old_rank = w_rank[w_idx];

    always_comb begin
        n_valid = w_valid;
        n_valid[w_idx] = 1'b1;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (IDX_BITS'(k) == w_idx) begin
                n_rank[k] = '0;
            end else if (w_valid[k] && (w_pick.fill_empty || (w_rank[k] < w_old_rank))) begin
                n_rank[k] = w_rank[k] + 1'b1;
            end else begin
                n_rank[k] = w_rank[k];
            end
        end
        n_faults = w_faults;
        if (!w_pick.hit && (w_faults != {COUNT_BITS{1'b1}})) begin
            n_faults = w_faults + 1'b1;
        end
        n_accesses = w_accesses;
        if (w_accesses != {COUNT_BITS{1'b1}}) begin
            n_accesses = w_accesses + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_faults   <= '0;
            r_accesses <= '0;
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_rank[k] <= '0;
            end
        end else if (w_fire) begin
            r_valid    <= n_valid;
            r_faults   <= n_faults;
            r_accesses <= n_accesses;
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_rank[k] <= n_rank[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && !w_pick.hit) begin
            r_page[w_idx] <= r_in_page;
        end
    end

    assign w_idx_ext = {{pfr_pkg::FRAME_W{1'b0}}, w_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_hit      <= w_pick.hit;
            r_out_frame    <= w_idx_ext[pfr_pkg::FRAME_W-1:0];
            r_out_faults   <= n_faults;
            r_out_accesses <= n_accesses;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_accesses, r_out_faults, r_out_frame};

endmodule

FILE: rtl/pfr_select.sv
// ----------------------------------------------------------------------------
// pfr_select: frame selection for one page reference
// Picks the lowest matching frame in the window, else the lowest empty frame,
// else the window frame with the highest recency rank (lowest index on ties).
// ----------------------------------------------------------------------------
module pfr_select #(
    parameter int MAX_FRAMES = 8,
    parameter int IDX_BITS   = 3
) (
    input  logic [MAX_FRAMES-1:0] i_match,
    input  logic [MAX_FRAMES-1:0] i_valid,
    input  logic [MAX_FRAMES-1:0] i_in_win,
    input  logic [IDX_BITS-1:0]   i_rank [MAX_FRAMES],
    output logic [IDX_BITS-1:0]   o_idx,
    output pfr_pkg::t_pick        o_pick
);

    logic                hit_found;
    logic [IDX_BITS-1:0] hit_idx;
    logic                empty_found;
    logic [IDX_BITS-1:0] empty_idx;
    logic [IDX_BITS-1:0] victim_idx;
    logic [IDX_BITS-1:0] victim_rank;

    always_comb begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
            if (i_in_win[k] && i_match[k]) begin
                hit_found = 1'b1;
                hit_idx   = IDX_BITS'(k);
            end
            if (i_in_win[k] && !i_valid[k]) begin
                empty_found = 1'b1;
                empty_idx   = IDX_BITS'(k);
            end
        end
    end

    always_comb begin
        victim_idx  = '0;
        victim_rank = i_rank[0];
        for (int k = 1; k < MAX_FRAMES; k++) begin
            if (i_in_win[k] && (i_rank[k] > victim_rank)) begin
                victim_idx  = IDX_BITS'(k);
                victim_rank = i_rank[k];
            end
        end
    end

    always_comb begin
        o_pick.hit        = hit_found;
        o_pick.fill_empty = !hit_found && empty_found;
        if (hit_found) begin
            o_idx = hit_idx;
        end else if (empty_found) begin
            o_idx = empty_idx;
        end else begin
            o_idx = victim_idx;
        end
    end

endmodule

FILE: tb/pfr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfr_checker: result checker for the page frame replacement block
// Watches the APB port and both stream channels, keeps its own LRU model of
// the frames, ranks and run counters, predicts one result per accepted page
// reference and compares every delivered result field by field in order.
// ----------------------------------------------------------------------------
module pfr_checker #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0]    i_s_tdata,
    input  logic                              i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [((pfr_pkg::FRAME_W+2*COUNT_BITS+7)/8)*8-1:0] i_m_tdata,
    input  logic                              i_m_tuser,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [pfr_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  logic [pfr_pkg::APB_DATA_W-1:0]    i_pwdata,
    input  logic [pfr_pkg::APB_DATA_W-1:0]    i_prdata,
    input  logic                              i_pready,
    output int                                o_errors,
    output int                                o_pending
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                        hit;
        logic [pfr_pkg::FRAME_W-1:0] frame;
        logic [COUNT_BITS-1:0]       faults;
        logic [COUNT_BITS-1:0]       accesses;
    } t_access_result;

    logic [pfr_pkg::CFG_W-1:0]   frames_cfg;
    logic                        slot_valid [MAX_FRAMES];
    logic [PAGE_BITS-1:0]        slot_page  [MAX_FRAMES];
    logic [pfr_pkg::FRAME_W-1:0] slot_rank  [MAX_FRAMES];
    logic [COUNT_BITS-1:0]       run_faults;
    logic [COUNT_BITS-1:0]       run_accesses;
    t_access_result              pending_results [$];

    task automatic clear_frames();
        int k;
        begin
            for (k = 0; k < MAX_FRAMES; k++) begin
                slot_valid[k] = 1'b0;
                slot_page[k]  = '0;
                slot_rank[k]  = '0;
            end
            run_faults   = '0;
            run_accesses = '0;
        end
    endtask

    task automatic predict_access(input logic [PAGE_BITS-1:0] pg, input logic fresh_run,
                                  output t_access_result res);
        int  k;
        int  win;
        int  f;
        int  old_rank;
        bit  found;
        begin
            if (fresh_run)
                clear_frames();
            win = int'(frames_cfg);
            if (win < 1)
                win = 1;
            if (win > MAX_FRAMES)
                win = MAX_FRAMES;
            f     = -1;
            found = 1'b0;
            for (k = 0; k < win; k++) begin
                if (!found && slot_valid[k] && slot_page[k] == pg) begin
                    f     = k;
                    found = 1'b1;
                end
            end
            if (found) begin
                old_rank = int'(slot_rank[f]);
            end else begin
                for (k = 0; k < win; k++) begin
                    if (f < 0 && !slot_valid[k])
                        f = k;
                end
                if (f < 0) begin
                    f = 0;
                    for (k = 1; k < win; k++) begin
                        if (slot_rank[k] > slot_rank[f])
                            f = k;
                    end
                    old_rank = int'(slot_rank[f]);
                end else begin
                    old_rank = MAX_FRAMES;
                end
            end
            for (k = 0; k < MAX_FRAMES; k++) begin
                if (k != f && slot_valid[k] && int'(slot_rank[k]) < old_rank)
                    slot_rank[k] = slot_rank[k] + 1'b1;
            end
            slot_rank[f] = '0;
            if (!found) begin
                slot_valid[f] = 1'b1;
                slot_page[f]  = pg;
                if (run_faults != COUNT_MAX)
                    run_faults = run_faults + 1'b1;
            end
            if (run_accesses != COUNT_MAX)
                run_accesses = run_accesses + 1'b1;
            res.hit      = found;
            res.frame    = pfr_pkg::FRAME_W'(f);
            res.faults   = run_faults;
            res.accesses = run_accesses;
        end
    endtask

    always @(posedge i_clk) begin
        t_access_result exp_res;
        t_access_result got_res;
        if (!i_rst_n) begin
            frames_cfg = pfr_pkg::FRAMES_IN_USE_RESET;
            clear_frames();
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready
                    && i_paddr[pfr_pkg::APB_ADDR_W-1:2] == pfr_pkg::REG_FRAMES_IN_USE) begin
                if (i_pwrite) begin
                    frames_cfg = i_pwdata[pfr_pkg::CFG_W-1:0];
                end else if (i_prdata != pfr_pkg::APB_DATA_W'(frames_cfg)) begin
                    $error("frames_in_use mismatch: expected %0d, actual %0d",
                           frames_cfg, i_prdata);
                    o_errors++;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got_res.hit      = i_m_tuser;
                got_res.frame    = i_m_tdata[pfr_pkg::FRAME_W-1:0];
                got_res.faults   = i_m_tdata[pfr_pkg::FRAME_W +: COUNT_BITS];
                got_res.accesses = i_m_tdata[pfr_pkg::FRAME_W+COUNT_BITS +: COUNT_BITS];
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: hit %0d, frame %0d",
                           got_res.hit, got_res.frame);
                    o_errors++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (got_res.hit != exp_res.hit) begin
                        $error("hit mismatch: expected %0d, actual %0d",
                               exp_res.hit, got_res.hit);
                        o_errors++;
                    end
                    if (got_res.frame != exp_res.frame) begin
                        $error("frame mismatch: expected %0d, actual %0d",
                               exp_res.frame, got_res.frame);
                        o_errors++;
                    end
                    if (got_res.faults != exp_res.faults) begin
                        $error("fault_count mismatch: expected %0d, actual %0d",
                               exp_res.faults, got_res.faults);
                        o_errors++;
                    end
                    if (got_res.accesses != exp_res.accesses) begin
                        $error("access_count mismatch: expected %0d, actual %0d",
                               exp_res.accesses, got_res.accesses);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_access(i_s_tdata[PAGE_BITS-1:0], i_s_tuser, exp_res);
                pending_results.push_back(exp_res);
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the page frame replacement block
// Drives page references and frames_in_use settings, varies idling on both
// stream sides, forces long receiver stalls and ends with a run of misses.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PAGE_W      = 8;
    localparam int RES_W       = 40;
    localparam int NUM_SEGS    = 12;
    localparam int SEG_ITEMS   = 140;
    localparam int MISS_ITEMS  = 40;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 4;

    localparam logic [pfr_pkg::APB_ADDR_W-1:0] ADDR_FRAMES   =
        {pfr_pkg::REG_FRAMES_IN_USE, 2'b00};
    localparam logic [pfr_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED =
        {~pfr_pkg::REG_FRAMES_IN_USE, 2'b00};

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [PAGE_W-1:0]              s_axis_tdata;
    logic                           s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [RES_W-1:0]               m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [pfr_pkg::APB_ADDR_W-1:0] paddr;
    logic [pfr_pkg::APB_DATA_W-1:0] pwdata;
    logic [pfr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int error_total;
    int results_due;
    int tx_idle_pct;
    int rx_idle_pct;
    int quiet_cycles;
    bit rx_hold;

    page_frame_replacement DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pfr_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .o_errors   (error_total),
        .o_pending  (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_access(input bit wr, input logic [pfr_pkg::APB_ADDR_W-1:0] addr,
                              input logic [pfr_pkg::APB_DATA_W-1:0] data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= wr;
            paddr   <= addr;
            pwdata  <= data;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic fresh_run);
        begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= pg;
            s_axis_tuser  <= fresh_run;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (results_due != 0) @(posedge i_clk);
            repeat (DRAIN_WAIT) @(posedge i_clk);
        end
    endtask

    task automatic set_frames(input logic [pfr_pkg::CFG_W-1:0] n);
        begin
            drain();
            apb_access(1'b1, ADDR_FRAMES, pfr_pkg::APB_DATA_W'(n));
            apb_access(1'b0, ADDR_FRAMES, '0);
        end
    endtask

    initial begin
        int                seg_frames [NUM_SEGS];
        logic [PAGE_W-1:0] page_pool [10];
        logic [PAGE_W-1:0] pg;
        int                pool_n;
        int                s;
        int                n;

        seg_frames    = '{1, 8, 2, 4, 9, 3, 0, 6, 15, 5, 7, 8};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_hold       = 1'b0;
        tx_idle_pct   = 8;
        rx_idle_pct   = 50;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_access(1'b0, ADDR_FRAMES, '0);
        send_ref(8'h00, 1'b0);
        send_ref(8'hFF, 1'b0);
        send_ref(8'h00, 1'b0);
        send_ref(8'h80, 1'b0);
        send_ref(8'h7F, 1'b0);
        send_ref(8'hFF, 1'b0);
        send_ref(8'h55, 1'b1);
        send_ref(8'hAA, 1'b0);
        send_ref(8'h33, 1'b0);
        // Shrinking the window leaves frames 1 and 2 resident but unsearched,
        // so the page in frame 1 ends up resident twice.
        set_frames(4'd1);
        send_ref(8'hAA, 1'b0);
        send_ref(8'hCC, 1'b0);
        send_ref(8'hAA, 1'b0);
        set_frames(4'd3);
        send_ref(8'hAA, 1'b0);
        send_ref(8'h33, 1'b0);
        send_ref(8'h01, 1'b0);
        set_frames(4'd0);
        send_ref(8'h33, 1'b0);
        send_ref(8'h02, 1'b0);
        set_frames(4'd15);
        for (n = 0; n < 7; n++)
            send_ref(PAGE_W'(8'h10 + n), 1'b0);
        send_ref(8'h33, 1'b0);
        drain();
        apb_access(1'b1, ADDR_UNMAPPED, 32'h0000_0007);
        apb_access(1'b0, ADDR_FRAMES, '0);

        for (s = 0; s < NUM_SEGS; s++) begin
            set_frames(seg_frames[s][pfr_pkg::CFG_W-1:0]);
            if (s == NUM_SEGS / 3) begin
                tx_idle_pct = 50;
                rx_idle_pct = 8;
            end else if (s == 2 * NUM_SEGS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (s == 2 || s == 9)
                rx_hold = 1'b1;
            pool_n = seg_frames[s] + 2;
            if (pool_n > 10)
                pool_n = 10;
            if (pool_n < 3)
                pool_n = 3;
            for (n = 0; n < pool_n; n++)
                page_pool[n] = PAGE_W'($urandom);
            for (n = 0; n < SEG_ITEMS; n++) begin
                if ($urandom_range(99) < 75)
                    pg = page_pool[$urandom_range(pool_n - 1)];
                else
                    pg = PAGE_W'($urandom_range(255));
                send_ref(pg, $urandom_range(99) < 2);
            end
        end

        // Every reference misses in a one-frame window, then one repeat hits and a new-run repeat misses.
        set_frames(4'd1);
        pg = PAGE_W'($urandom);
        send_ref(pg, 1'b1);
        for (n = 0; n < MISS_ITEMS; n++) begin
            pg = pg ^ PAGE_W'($urandom_range(255, 1));
            send_ref(pg, 1'b0);
        end
        send_ref(pg, 1'b0);
        send_ref(pg, 1'b1);
        drain();

        if (error_total == 0 && results_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
